>>> sv/mip_pkg.sv
// ---------------------------------------------------------------------------
// mip_pkg
// Shared constants and register codes for the modular index permuter.
// ---------------------------------------------------------------------------
`default_nettype none

package mip_pkg;

   // default width of an index or location word
   localparam int VALUE_BITS_DEF = 44;

   // register file port: 64-bit data, registers on 8-byte strides
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_SEL_LSB   = 3;
   localparam int CSR_SEL_BITS  = CSR_ADDR_BITS - CSR_SEL_LSB;

   // register indexes
   typedef enum logic [CSR_SEL_BITS-1:0] {
      REG_MODULUS = 2'd0,
      REG_FWD_MUL = 2'd1,
      REG_INV_MUL = 2'd2
   } reg_index_type;

   // modulus after reset
   localparam logic [CSR_DATA_BITS-1:0] MODULUS_RESET = 64'd2;

endpackage

`default_nettype wire

>>> sv/mip_csr.sv
// ---------------------------------------------------------------------------
// mip_csr
// Register file: modulus and the two multipliers, written and read over an
// APB-style port.
// ---------------------------------------------------------------------------
`default_nettype none

module mip_csr #(
   parameter int VALUE_BITS = 44
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [mip_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [mip_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic      [mip_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                       pready,
   output logic      [VALUE_BITS:0]                   modulus,
   output logic      [VALUE_BITS-1:0]                 forward_multiplier,
   output logic      [VALUE_BITS-1:0]                 inverse_multiplier
);
   import mip_pkg::*;

   logic [VALUE_BITS:0]   modulus_ff;
   logic [VALUE_BITS-1:0] fwd_mul_ff;
   logic [VALUE_BITS-1:0] inv_mul_ff;
   logic                  wr_en;
   reg_index_type         sel;

   assign sel   = reg_index_type'(paddr[CSR_ADDR_BITS-1:CSR_SEL_LSB]);
   assign wr_en = psel && penable && pwrite;

   // write a register at the access cycle; unknown indexes drop the word
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[VALUE_BITS:0];
         fwd_mul_ff <= '0;
         inv_mul_ff <= '0;
      end else if (wr_en) begin
         unique case (sel)
            REG_MODULUS: modulus_ff <= pwdata[VALUE_BITS:0];
            REG_FWD_MUL: fwd_mul_ff <= pwdata[VALUE_BITS-1:0];
            REG_INV_MUL: inv_mul_ff <= pwdata[VALUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (sel)
         REG_MODULUS: prdata = CSR_DATA_BITS'(modulus_ff);
         REG_FWD_MUL: prdata = CSR_DATA_BITS'(fwd_mul_ff);
         REG_INV_MUL: prdata = CSR_DATA_BITS'(inv_mul_ff);
         default:     prdata = '0;
      endcase
   end

   assign pready             = 1'b1;
   assign modulus            = modulus_ff;
   assign forward_multiplier = fwd_mul_ff;
   assign inverse_multiplier = inv_mul_ff;

endmodule

`default_nettype wire

>>> sv/mip_rcell.sv
// ---------------------------------------------------------------------------
// mip_rcell
// Reduction cell: folds one bit of the multiplier into a running remainder,
// so the chain of these cells delivers multiplier mod modulus.
// ---------------------------------------------------------------------------
`default_nettype none

module mip_rcell #(
   parameter int VALUE_BITS = 44,
   parameter int POS        = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic [VALUE_BITS:0]   mod_eff,
   input  wire logic                  in_valid,
   input  wire logic [VALUE_BITS-1:0] in_k,
   input  wire logic [VALUE_BITS-1:0] in_b,
   input  wire logic [VALUE_BITS-1:0] in_acc,
   output logic                       out_valid,
   output logic      [VALUE_BITS-1:0] out_k,
   output logic      [VALUE_BITS-1:0] out_b,
   output logic      [VALUE_BITS-1:0] out_acc
);
   import mip_pkg::*;

   logic                  valid_ff;
   logic [VALUE_BITS-1:0] k_ff;
   logic [VALUE_BITS-1:0] b_ff;
   logic [VALUE_BITS-1:0] acc_ff;
   logic [VALUE_BITS-1:0] acc_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;

   // shift in the next multiplier bit, subtract modulus once if needed
   always_comb begin
      trial  = {in_acc, in_b[POS]};
      diff   = trial - mod_eff;
      acc_in = (trial >= mod_eff) ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
   end

   // advance with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff   <= in_k;
         b_ff   <= in_b;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_k     = k_ff;
   assign out_b     = b_ff;
   assign out_acc   = acc_ff;

endmodule

`default_nettype wire

>>> sv/mip_mcell.sv
// ---------------------------------------------------------------------------
// mip_mcell
// Multiply cell: one double-and-add step of the modular product, keeping
// the partial sum below the modulus.
// ---------------------------------------------------------------------------
`default_nettype none

module mip_mcell #(
   parameter int VALUE_BITS = 44,
   parameter int POS        = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic [VALUE_BITS:0]   mod_eff,
   input  wire logic                  in_valid,
   input  wire logic [VALUE_BITS-1:0] in_k,
   input  wire logic [VALUE_BITS-1:0] in_bm,
   input  wire logic [VALUE_BITS-1:0] in_r,
   output logic                       out_valid,
   output logic      [VALUE_BITS-1:0] out_k,
   output logic      [VALUE_BITS-1:0] out_bm,
   output logic      [VALUE_BITS-1:0] out_r
);
   import mip_pkg::*;

   logic                  valid_ff;
   logic [VALUE_BITS-1:0] k_ff;
   logic [VALUE_BITS-1:0] bm_ff;
   logic [VALUE_BITS-1:0] r_ff;
   logic [VALUE_BITS-1:0] r_in;
   logic [VALUE_BITS:0]   dbl;
   logic [VALUE_BITS:0]   dbl_diff;
   logic [VALUE_BITS-1:0] dbl_red;
   logic [VALUE_BITS:0]   sum;
   logic [VALUE_BITS:0]   sum_diff;

   // double mod m, then add the reduced multiplier when the index bit is set
   always_comb begin
      dbl      = {in_r, 1'b0};
      dbl_diff = dbl - mod_eff;
      dbl_red  = (dbl >= mod_eff) ? dbl_diff[VALUE_BITS-1:0] : dbl[VALUE_BITS-1:0];
      sum      = {1'b0, dbl_red} + (in_k[POS] ? {1'b0, in_bm} : '0);
      sum_diff = sum - mod_eff;
      r_in     = (sum >= mod_eff) ? sum_diff[VALUE_BITS-1:0] : sum[VALUE_BITS-1:0];
   end

   // advance with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff  <= in_k;
         bm_ff <= in_bm;
         r_ff  <= r_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_k     = k_ff;
   assign out_bm    = bm_ff;
   assign out_r     = r_ff;

endmodule

`default_nettype wire

>>> sv/modular_index_permuter_unit.sv
// ---------------------------------------------------------------------------
// modular_index_permuter_unit
// Maps an index to a location (op 0) or back (op 1) as
// (index_in * multiplier) mod modulus, exact for any operand.
// ---------------------------------------------------------------------------
// The unit takes one word per cycle while no result is stalled and returns
// one word per input, in order. The datapath is a row of cells, one bit
// per cell: VALUE_BITS cells reduce the selected multiplier modulo the
// modulus, then VALUE_BITS cells run the double-and-add product, and the
// last cell's register is the result register. The whole row holds while a
// result is stalled, so req_stall follows rsp_stall whenever a result
// waits. A modulus of zero yields 0; a modulus above 2^VALUE_BITS acts as
// 2^VALUE_BITS. Write the registers only while no word is in flight.
`default_nettype none

module modular_index_permuter_unit #(
   parameter int VALUE_BITS = mip_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [VALUE_BITS-1:0]             req_index_in,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [VALUE_BITS-1:0]             rsp_mapped_value,
   // register port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [mip_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [mip_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [mip_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready
);
   import mip_pkg::*;

   localparam logic [VALUE_BITS:0] MOD_MAX = {1'b1, {VALUE_BITS{1'b0}}};

   logic [VALUE_BITS:0]   modulus;
   logic [VALUE_BITS-1:0] fwd_mul;
   logic [VALUE_BITS-1:0] inv_mul;
   logic [VALUE_BITS:0]   mod_eff;
   logic                  mod_zero;
   logic                  en;

   // reduction chain links
   logic                  r_valid [0:VALUE_BITS];
   logic [VALUE_BITS-1:0] r_k     [0:VALUE_BITS];
   logic [VALUE_BITS-1:0] r_b     [0:VALUE_BITS-1];
   logic [VALUE_BITS-1:0] r_acc   [0:VALUE_BITS];

   // product chain links
   logic                  m_valid [0:VALUE_BITS];
   logic [VALUE_BITS-1:0] m_k     [0:VALUE_BITS-1];
   logic [VALUE_BITS-1:0] m_bm    [0:VALUE_BITS-1];
   logic [VALUE_BITS-1:0] m_r     [0:VALUE_BITS];

   mip_csr #(
      .VALUE_BITS(VALUE_BITS)
   ) u_csr (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .modulus            (modulus),
      .forward_multiplier (fwd_mul),
      .inverse_multiplier (inv_mul)
   );

   // clamp the modulus to the output range
   assign mod_eff  = (modulus > MOD_MAX) ? MOD_MAX : modulus;
   assign mod_zero = (modulus == '0);

   // hold the whole row while a result waits on a stall
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // feed the first cell straight from the input word
   assign r_valid[0] = req_valid;
   assign r_k[0]     = req_index_in;
   assign r_b[0]     = req_op ? inv_mul : fwd_mul;
   assign r_acc[0]   = '0;

   // multiplier mod modulus, most significant bit first
   for (genvar j = 0; j < VALUE_BITS; j++) begin : g_red
      if (j == VALUE_BITS - 1) begin : g_last
         mip_rcell #(
            .VALUE_BITS(VALUE_BITS),
            .POS       (VALUE_BITS - 1 - j)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .mod_eff   (mod_eff),
            .in_valid  (r_valid[j]),
            .in_k      (r_k[j]),
            .in_b      (r_b[j]),
            .in_acc    (r_acc[j]),
            .out_valid (r_valid[j+1]),
            .out_k     (r_k[j+1]),
            .out_b     (),
            .out_acc   (r_acc[j+1])
         );
      end else begin : g_mid
         mip_rcell #(
            .VALUE_BITS(VALUE_BITS),
            .POS       (VALUE_BITS - 1 - j)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .mod_eff   (mod_eff),
            .in_valid  (r_valid[j]),
            .in_k      (r_k[j]),
            .in_b      (r_b[j]),
            .in_acc    (r_acc[j]),
            .out_valid (r_valid[j+1]),
            .out_k     (r_k[j+1]),
            .out_b     (r_b[j+1]),
            .out_acc   (r_acc[j+1])
         );
      end
   end

   // hand the reduced multiplier to the product chain
   assign m_valid[0] = r_valid[VALUE_BITS];
   assign m_k[0]     = r_k[VALUE_BITS];
   assign m_bm[0]    = r_acc[VALUE_BITS];
   assign m_r[0]     = '0;

   // double-and-add over the index bits, most significant first
   for (genvar j = 0; j < VALUE_BITS; j++) begin : g_mul
      if (j == VALUE_BITS - 1) begin : g_last
         mip_mcell #(
            .VALUE_BITS(VALUE_BITS),
            .POS       (VALUE_BITS - 1 - j)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .mod_eff   (mod_eff),
            .in_valid  (m_valid[j]),
            .in_k      (m_k[j]),
            .in_bm     (m_bm[j]),
            .in_r      (m_r[j]),
            .out_valid (m_valid[j+1]),
            .out_k     (),
            .out_bm    (),
            .out_r     (m_r[j+1])
         );
      end else begin : g_mid
         mip_mcell #(
            .VALUE_BITS(VALUE_BITS),
            .POS       (VALUE_BITS - 1 - j)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .mod_eff   (mod_eff),
            .in_valid  (m_valid[j]),
            .in_k      (m_k[j]),
            .in_bm     (m_bm[j]),
            .in_r      (m_r[j]),
            .out_valid (m_valid[j+1]),
            .out_k     (m_k[j+1]),
            .out_bm    (m_bm[j+1]),
            .out_r     (m_r[j+1])
         );
      end
   end

   // last cell register drives the result; a zero modulus gives zero
   assign rsp_valid        = m_valid[VALUE_BITS];
   assign rsp_mapped_value = mod_zero ? '0 : m_r[VALUE_BITS];

endmodule

`default_nettype wire

>>> sim/modular_index_permuter_unit_test.sv
// ---------------------------------------------------------------------------
// modular_index_permuter_unit_test
// Self-checking bench for the modular index permuter. Register settings are
// applied through the APB port while the unit is idle. Index words stream in
// under random valid gaps and result stalls. Every result word is compared
// in order against a wide-multiply-and-remainder prediction.
// ---------------------------------------------------------------------------
module modular_index_permuter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mip_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEF;
   localparam int RANDOM_WORDS = 830;
   localparam int CALM_AFTER = 700;

   // operation codes on req_op
   localparam logic OP_TO_LOCATION = 1'b0;
   localparam logic OP_TO_INDEX    = 1'b1;

   // register index past the end of the register file
   localparam logic [CSR_SEL_BITS-1:0] REG_SPARE = 2'd3;

   localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam logic [VALUE_BITS:0] MODULUS_CAP = {1'b1, {VALUE_BITS{1'b0}}};

   typedef struct {
      logic                  op;
      logic [VALUE_BITS-1:0] index_in;
   } request_word;

   typedef struct {
      request_word           req;
      logic [VALUE_BITS-1:0] mapped_value;
   } mapping_word;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = OP_TO_LOCATION;
   logic [VALUE_BITS-1:0]   req_index_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0]   rsp_mapped_value;

   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // shadow copy of the register file
   logic [VALUE_BITS:0]   modulus_q = (VALUE_BITS+1)'(MODULUS_RESET);
   logic [VALUE_BITS-1:0] fwd_mul_q = '0;
   logic [VALUE_BITS-1:0] inv_mul_q = '0;

   request_word queued_requests[$];
   mapping_word expected_mappings[$];

   int  mismatch_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  random_sent = 0;
   int  phase_size;
   bit  calm = 1'b0;

   modular_index_permuter_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_index_in    (req_index_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mapped_value(rsp_mapped_value),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [VALUE_BITS:0] effective_modulus();
      return (modulus_q > MODULUS_CAP) ? MODULUS_CAP : modulus_q;
   endfunction

   // exact product through a double-width multiply, then one remainder
   function automatic logic [VALUE_BITS-1:0] modular_product(
      input logic op, input logic [VALUE_BITS-1:0] index_in);
      logic [VALUE_BITS:0]     m;
      logic [VALUE_BITS-1:0]   mult;
      logic [2*VALUE_BITS:0]   prod;
      m = effective_modulus();
      mult = (op == OP_TO_INDEX) ? inv_mul_q : fwd_mul_q;
      if (m == 0)
         return '0;
      prod = index_in * mult;
      return VALUE_BITS'(prod % m);
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // mostly below the modulus, keeping random junk above the field
   function automatic logic [63:0] random_multiplier();
      logic [63:0]         r;
      logic [VALUE_BITS:0] m;
      r = rand_word();
      m = effective_modulus();
      if (m == 0 || $urandom_range(0, 3) == 0)
         return r;
      return (r & ~VALUE_MASK) | (r % m);
   endfunction

   // setup cycle, access cycle, then wait for pready
   task automatic write_register(input logic [CSR_SEL_BITS-1:0] sel,
                                 input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(sel) << CSR_SEL_LSB;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (sel)
         REG_MODULUS: modulus_q = value[VALUE_BITS:0];
         REG_FWD_MUL: fwd_mul_q = value[VALUE_BITS-1:0];
         REG_INV_MUL: inv_mul_q = value[VALUE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_item(input logic op, input logic [VALUE_BITS-1:0] index_in);
      request_word w;
      w.op = op;
      w.index_in = index_in;
      queued_requests.push_back(w);
   endtask

   task automatic queue_random_items(input int count);
      logic [VALUE_BITS:0] m;
      logic [63:0]         r;
      m = effective_modulus();
      repeat (count) begin
         r = rand_word();
         if (m > 1 && $urandom_range(0, 6) != 0)
            r = r % m;
         queue_item(1'($urandom_range(0, 1)), r[VALUE_BITS-1:0]);
      end
   endtask

   // hold until every word is sent and every result is back
   task automatic wait_idle();
      do
         @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || expected_mappings.size() != 0);
   endtask

   task automatic pick_random_setting();
      logic [63:0] m_word;
      case ($urandom_range(0, 5))
         0: m_word = 64'($urandom_range(2, 300));
         1: m_word = rand_word();
         2: m_word = rand_word() & VALUE_MASK;
         3: m_word = (64'd1 << VALUE_BITS) - $urandom_range(0, 1000);
         4: m_word = (64'd1 << 32) + $urandom_range(0, 2000) - 64'd1000;
         default: m_word = (64'd1 << $urandom_range(1, VALUE_BITS)) + $urandom_range(0, 3);
      endcase
      write_register(REG_MODULUS, m_word);
      write_register(REG_FWD_MUL, random_multiplier());
      write_register(REG_INV_MUL, random_multiplier());
   endtask

   // Driver: present the next word, hold it while stalled, insert gaps
   always @(posedge clock) begin
      request_word w;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_mappings.push_back('{'{req_op, req_index_in},
                                          modular_product(req_op, req_index_in)});
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (queued_requests.size() != 0) begin
               w = queued_requests.pop_front();
               req_valid    <= 1'b1;
               req_op       <= w.op;
               req_index_in <= w.index_in;
               if (!calm && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result word, stall in random bursts
   always @(posedge clock) begin
      mapping_word e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mappings.size() == 0) begin
               report_mismatch($sformatf("unexpected result word %h", rsp_mapped_value));
            end else begin
               e = expected_mappings.pop_front();
               if (rsp_mapped_value !== e.mapped_value)
                  report_mismatch($sformatf("op %0d index %h: mapped_value %h, want %h",
                     e.req.op, e.req.index_in, rsp_mapped_value, e.mapped_value));
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(0, 9) == 0)
               stall_left = $urandom_range(1, 4);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset setting: modulus 2, both multipliers zero
      @(negedge clock);
      queue_item(OP_TO_LOCATION, VALUE_MAX);
      queue_item(OP_TO_INDEX, 1);
      wait_idle();

      // largest exact modulus, all-ones multipliers, the forward one written with junk above
      write_register(REG_MODULUS, 64'd1 << VALUE_BITS);
      write_register(REG_FWD_MUL, '1);
      write_register(REG_INV_MUL, VALUE_MASK);
      @(negedge clock);
      queue_item(OP_TO_LOCATION, 0);
      queue_item(OP_TO_INDEX, 0);
      queue_item(OP_TO_LOCATION, VALUE_MAX);
      queue_item(OP_TO_INDEX, VALUE_MAX);
      queue_item(OP_TO_LOCATION, 1);
      queue_item(OP_TO_INDEX, 1);
      queue_item(OP_TO_LOCATION, VALUE_BITS'(64'd1 << (VALUE_BITS - 1)));
      wait_idle();

      // modulus above the cap clamps to 2^VALUE_BITS
      write_register(REG_MODULUS, '1);
      write_register(REG_FWD_MUL, 3);
      write_register(REG_INV_MUL, (64'd1 << (VALUE_BITS - 1)) + 64'd5);
      @(negedge clock);
      queue_item(OP_TO_LOCATION, VALUE_MAX);
      queue_item(OP_TO_INDEX, VALUE_MAX);
      queue_item(OP_TO_INDEX, 12345);
      wait_idle();

      // modulus zero maps everything to zero
      write_register(REG_MODULUS, 0);
      @(negedge clock);
      queue_item(OP_TO_LOCATION, VALUE_MAX);
      queue_item(OP_TO_INDEX, 7);
      wait_idle();

      // modulus one
      write_register(REG_MODULUS, 1);
      write_register(REG_FWD_MUL, 5);
      @(negedge clock);
      queue_item(OP_TO_LOCATION, 9);
      queue_item(OP_TO_INDEX, VALUE_MAX);
      wait_idle();

      // operands not below the modulus; a write past the register file is dropped
      write_register(REG_MODULUS, 7);
      write_register(REG_FWD_MUL, VALUE_MASK);
      write_register(REG_INV_MUL, 100);
      write_register(REG_SPARE, rand_word());
      @(negedge clock);
      queue_item(OP_TO_LOCATION, 6);
      queue_item(OP_TO_INDEX, VALUE_MAX);
      queue_item(OP_TO_LOCATION, 7);
      queue_item(OP_TO_INDEX, 3);
      wait_idle();

      // random settings, each followed by a stream of random words
      while (random_sent < RANDOM_WORDS) begin
         phase_size = $urandom_range(40, 110);
         if (phase_size > RANDOM_WORDS - random_sent)
            phase_size = RANDOM_WORDS - random_sent;
         calm = (random_sent >= CALM_AFTER);
         pick_random_setting();
         @(negedge clock);
         queue_random_items(phase_size);
         random_sent += phase_size;
         wait_idle();
      end

      repeat (2 * VALUE_BITS + 8) @(posedge clock);
      if (expected_mappings.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived",
                                   expected_mappings.size()));
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
